// ===== rtl/core/xbr_pkg.sv =====
// ----------------------------------------------------------------------------
// xbr_pkg: shared types and constants of the x86 branch resolver
// Opcodes, class codes, beat layouts and the condition code helper.
// ----------------------------------------------------------------------------
package xbr_pkg;

  // beat widths
  localparam int unsigned InDataW  = 320;
  localparam int unsigned OutDataW = 240;

  // opcodes
  localparam logic [7:0] OP_CALL_REL32 = 8'hE8;
  localparam logic [7:0] OP_JMP_REL32  = 8'hE9;
  localparam logic [7:0] OP_JMP_REL8   = 8'hEB;
  localparam logic [7:0] OP_LOOP       = 8'hE2;
  localparam logic [7:0] OP_LOOPNE     = 8'hE0;
  localparam logic [7:0] OP_LOOPE      = 8'hE1;
  localparam logic [7:0] OP_RET_IMM    = 8'hC2;
  localparam logic [7:0] OP_RET        = 8'hC3;
  localparam logic [7:0] OP_JCXZ       = 8'hE3;
  localparam logic [7:0] OP_TWO_BYTE   = 8'h0F;
  localparam logic [7:0] OP_GRP5       = 8'hFF;
  localparam logic [7:0] PFX_ADDR      = 8'h67;
  localparam logic [7:0] PFX_OPND      = 8'h66;
  localparam logic [3:0] JCC_SHORT_HI  = 4'h7;
  localparam logic [3:0] JCC_NEAR_HI   = 4'h8;
  localparam logic [2:0] GRP5_CALL     = 3'd2;
  localparam logic [2:0] GRP5_JMP      = 3'd4;
  localparam logic [3:0] RET_IMM_LEN   = 4'd3;

  // eflags bit positions
  localparam int unsigned FlagCf = 0;
  localparam int unsigned FlagPf = 2;
  localparam int unsigned FlagZf = 6;
  localparam int unsigned FlagSf = 7;
  localparam int unsigned FlagOf = 11;

  // register indexes of the config port
  localparam logic CFG_CODE_BASE = 1'b0;
  localparam logic CFG_CODE_SIZE = 1'b1;

  typedef enum logic [3:0] {
    CLS_GENERIC   = 4'd0,
    CLS_CALL_DIR  = 4'd1,
    CLS_CALL_IND  = 4'd2,
    CLS_JMP_IND   = 4'd3,
    CLS_JMP32     = 4'd4,
    CLS_JMP8      = 4'd5,
    CLS_LOOP      = 4'd6,
    CLS_LOOPNE    = 4'd7,
    CLS_LOOPE     = 4'd8,
    CLS_RET       = 4'd9,
    CLS_JCC       = 4'd10
  } instr_class_t;

  typedef struct packed {
    logic [47:0] instr_bytes;
    logic [3:0]  instr_length;
    logic [11:0] flags_word;
    logic [63:0] count_reg;
    logic [63:0] stack_ptr;
    logic [63:0] stack_top;
    logic [63:0] modrm_reg_value;
  } xbr_item_t;

  typedef struct packed {
    instr_class_t instr_class;
    logic         handled_here;
    logic         branch_taken;
    logic [31:0]  next_offset;
    logic [63:0]  new_count_reg;
    logic [63:0]  new_stack_ptr;
    logic         push_valid;
    logic [63:0]  push_value;
    logic         target_in_code;
    logic         unsupported;
  } xbr_result_t;

  // code window as seen by the resolver
  typedef struct packed {
    logic [63:0] code_base;
    logic [63:0] code_limit;
  } xbr_cfg_t;

  function automatic logic [31:0] sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  // x86 condition code evaluation, low bit inverts
  function automatic logic cond_code(input logic [3:0] c, input logic [11:0] fl);
    logic r;
    case (c[3:1])
      3'd0: r = fl[FlagOf];
      3'd1: r = fl[FlagCf];
      3'd2: r = fl[FlagZf];
      3'd3: r = fl[FlagCf] | fl[FlagZf];
      3'd4: r = fl[FlagSf];
      3'd5: r = fl[FlagPf];
      3'd6: r = fl[FlagSf] ^ fl[FlagOf];
      default: r = fl[FlagZf] | (fl[FlagSf] ^ fl[FlagOf]);
    endcase
    return c[0] ? ~r : r;
  endfunction

endpackage

// ===== rtl/core/x86_branch_resolver_top.sv =====
// ----------------------------------------------------------------------------
// x86_branch_resolver_top: branch resolver for stepped x86-64 code
// Input register, resolve logic with the offset register, output register.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one decoded instruction per beat with its flags, RCX, RSP,
//           stack top value and ModRM register value.
//   out_* : one result beat per instruction, in order.
//   cfg_* : code base (index 0) and code size (index 1); write while idle.
// Path: a beat taken on in_* is written to the input register, resolved, and
//   then written to the output register that drives out_tvalid and out_tdata.
// Throughput: one instruction per cycle while out_tready is high; the code
//   offset register is updated in the cycle an instruction leaves the input
//   register, so the next instruction sees it right away. The longest path is
//   a 64-bit compare against the window bound and the three-input offset add.
// Reset (rst_n low, synchronous): both stages empty, code offset, base and
//   size cleared.
// Receiver stall: a result holds on out_tdata while out_tready is low; one
//   more instruction is held in the input register, then in_tready drops.
// ----------------------------------------------------------------------------
module x86_branch_resolver_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // instr_bytes, instr_length, flags_word, count_reg, stack_ptr,
  // stack_top, modrm_reg_value (low to high)
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [xbr_pkg::InDataW-1:0]   in_tdata,
  // instr_class, handled_here, branch_taken, next_offset, new_count_reg,
  // new_stack_ptr, push_valid, push_value, target_in_code, unsupported,
  // zero fill (low to high)
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [xbr_pkg::OutDataW-1:0]  out_tdata,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [63:0]                   cfg_wdata
);
  import xbr_pkg::*;

  xbr_cfg_t    cfg;
  xbr_item_t   item_r;
  xbr_result_t res;
  logic        s1_valid_r, s1_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] offset_r;
  logic [OutDataW-1:0] out_data_r;
  logic        in_fire, s1_go;

  xbr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  xbr_resolve u_resolve (
    .item_i   (item_r),
    .offset_i (offset_r),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // handshake
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_go ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // control state and code offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      offset_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        offset_r <= res.next_offset;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.instr_bytes     <= in_tdata[47:0];
      item_r.instr_length    <= in_tdata[51:48];
      item_r.flags_word      <= in_tdata[63:52];
      item_r.count_reg       <= in_tdata[127:64];
      item_r.stack_ptr       <= in_tdata[191:128];
      item_r.stack_top       <= in_tdata[255:192];
      item_r.modrm_reg_value <= in_tdata[319:256];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r <= {7'd0,
                     res.unsupported,
                     res.target_in_code,
                     res.push_value,
                     res.push_valid,
                     res.new_stack_ptr,
                     res.new_count_reg,
                     res.next_offset,
                     res.branch_taken,
                     res.handled_here,
                     res.instr_class};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/xbr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// xbr_cfg_regs: code window registers
// Holds code base and size and keeps the inclusive upper bound ready.
// ----------------------------------------------------------------------------
module xbr_cfg_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [63:0]           cfg_wdata,
  output xbr_pkg::xbr_cfg_t     cfg_o
);
  import xbr_pkg::*;

  logic [63:0] code_base_r;
  logic [31:0] code_size_r;
  logic [63:0] code_limit_r;

  // register writes, bound follows in the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_base_r  <= '0;
      code_size_r  <= '0;
      code_limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CODE_BASE: begin
          code_base_r  <= cfg_wdata;
          code_limit_r <= cfg_wdata + {32'd0, code_size_r};
        end
        CFG_CODE_SIZE: begin
          code_size_r  <= cfg_wdata[31:0];
          code_limit_r <= code_base_r + {32'd0, cfg_wdata[31:0]};
        end
        default: ;
      endcase
    end
  end

  assign cfg_o.code_base  = code_base_r;
  assign cfg_o.code_limit = code_limit_r;

endmodule

// ===== rtl/core/xbr_resolve.sv =====
// ----------------------------------------------------------------------------
// xbr_resolve: instruction classification and target resolution
// Decodes one instruction against the current offset and computes its result.
// ----------------------------------------------------------------------------
module xbr_resolve (
  input  xbr_pkg::xbr_item_t    item_i,
  input  logic [31:0]           offset_i,
  input  xbr_pkg::xbr_cfg_t     cfg_i,
  output xbr_pkg::xbr_result_t  res_o
);
  import xbr_pkg::*;

  logic [7:0]  b0, b1, b2;
  logic [31:0] seq;
  logic [32:0] off_len;
  logic [63:0] ret_addr;
  logic [31:0] disp32_b1, disp32_b2;
  logic [31:0] top_rel, rv_rel;
  logic [2:0]  modrm_reg;
  logic        rv_in;
  logic        is_jcc_short, is_jcc_near, is_cxz;
  logic        cxz_taken;
  logic [31:0] jcc_rel;
  logic        jcc_taken;
  logic [63:0] ret_pop;

  // byte fields and common sums
  assign b0        = item_i.instr_bytes[7:0];
  assign b1        = item_i.instr_bytes[15:8];
  assign b2        = item_i.instr_bytes[23:16];
  assign disp32_b1 = item_i.instr_bytes[39:8];
  assign disp32_b2 = item_i.instr_bytes[47:16];
  assign seq       = offset_i + {28'd0, item_i.instr_length};
  assign off_len   = {1'b0, offset_i} + {29'd0, item_i.instr_length};
  assign ret_addr  = cfg_i.code_base + {31'd0, off_len};
  assign top_rel   = item_i.stack_top[31:0] - cfg_i.code_base[31:0];
  assign rv_rel    = item_i.modrm_reg_value[31:0] - cfg_i.code_base[31:0];
  assign modrm_reg = b1[5:3];
  assign rv_in     = (item_i.modrm_reg_value >= cfg_i.code_base) &&
                     (item_i.modrm_reg_value <= cfg_i.code_limit);

  // conditional jump forms
  assign is_jcc_short = (b0[7:4] == JCC_SHORT_HI);
  assign is_jcc_near  = (b0 == OP_TWO_BYTE) && (b1[7:4] == JCC_NEAR_HI);
  assign is_cxz       = (b0 == OP_JCXZ) ||
                        (((b0 == PFX_ADDR) || (b0 == PFX_OPND)) && (b1 == OP_JCXZ));
  assign cxz_taken    = (b0 == PFX_ADDR) ? (item_i.count_reg[31:0] == 32'd0)
                                         : (item_i.count_reg == 64'd0);

  always_comb begin
    jcc_rel   = sext8(b2);
    jcc_taken = cxz_taken;
    if (is_jcc_short) begin
      jcc_rel   = sext8(b1);
      jcc_taken = cond_code(b0[3:0], item_i.flags_word);
    end else if (is_jcc_near) begin
      jcc_rel   = disp32_b2;
      jcc_taken = cond_code(b1[3:0], item_i.flags_word);
    end else if (b0 == OP_JCXZ) begin
      jcc_rel   = sext8(b1);
    end
  end

  // ret immediate pop only for the three byte form
  assign ret_pop = ((b0 == OP_RET_IMM) && (item_i.instr_length == RET_IMM_LEN))
                   ? {48'd0, b2, b1} : 64'd0;

  // result selection in decode priority
  always_comb begin
    res_o.instr_class    = CLS_GENERIC;
    res_o.handled_here   = 1'b0;
    res_o.branch_taken   = 1'b0;
    res_o.next_offset    = seq;
    res_o.new_count_reg  = item_i.count_reg;
    res_o.new_stack_ptr  = item_i.stack_ptr;
    res_o.push_valid     = 1'b0;
    res_o.push_value     = 64'd0;
    res_o.target_in_code = 1'b0;
    res_o.unsupported    = 1'b0;
    if (b0 == OP_CALL_REL32) begin
      res_o.instr_class   = CLS_CALL_DIR;
      res_o.handled_here  = 1'b1;
      res_o.new_stack_ptr = item_i.stack_ptr - 64'd8;
      res_o.push_valid    = 1'b1;
      res_o.push_value    = ret_addr;
      res_o.next_offset   = seq + disp32_b1;
    end else if (b0 == OP_JMP_REL32) begin
      res_o.instr_class   = CLS_JMP32;
      res_o.handled_here  = 1'b1;
      res_o.next_offset   = seq + disp32_b1;
    end else if (b0 == OP_JMP_REL8) begin
      res_o.instr_class   = CLS_JMP8;
      res_o.handled_here  = 1'b1;
      res_o.next_offset   = seq + sext8(b1);
    end else if (b0 == OP_LOOP) begin
      res_o.instr_class   = CLS_LOOP;
      res_o.handled_here  = 1'b1;
      res_o.new_count_reg = item_i.count_reg - 64'd1;
      res_o.branch_taken  = (item_i.count_reg != 64'd1);
      res_o.next_offset   = (item_i.count_reg != 64'd1) ? seq + sext8(b1) : seq;
    end else if ((b0 == OP_LOOPNE) || (b0 == OP_LOOPE)) begin
      res_o.instr_class   = (b0 == OP_LOOPNE) ? CLS_LOOPNE : CLS_LOOPE;
      res_o.unsupported   = 1'b1;
      res_o.next_offset   = offset_i;
    end else if ((b0 == OP_RET_IMM) || (b0 == OP_RET)) begin
      res_o.instr_class   = CLS_RET;
      res_o.handled_here  = 1'b1;
      res_o.new_stack_ptr = item_i.stack_ptr + 64'd8 + ret_pop;
      res_o.next_offset   = top_rel;
    end else if (is_jcc_short || is_jcc_near || is_cxz) begin
      res_o.instr_class   = CLS_JCC;
      res_o.handled_here  = 1'b1;
      res_o.branch_taken  = jcc_taken;
      res_o.next_offset   = jcc_taken ? seq + jcc_rel : seq;
    end else if ((b0 == OP_GRP5) && ((modrm_reg == GRP5_CALL) || (modrm_reg == GRP5_JMP))) begin
      res_o.instr_class    = (modrm_reg == GRP5_CALL) ? CLS_CALL_IND : CLS_JMP_IND;
      res_o.target_in_code = rv_in;
      if (rv_in) begin
        res_o.next_offset = rv_rel;
        if (modrm_reg == GRP5_CALL) begin
          res_o.new_stack_ptr = item_i.stack_ptr - 64'd8;
          res_o.push_valid    = 1'b1;
          res_o.push_value    = ret_addr;
        end
      end else if (modrm_reg == GRP5_JMP) begin
        // jump out of the window returns to the caller
        res_o.next_offset = top_rel;
      end
    end
  end

endmodule
